FILE: rtl/urd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_pkg: shared types and constants
// Widths, register codes, reset values, display fonts and the word format
// passed from the front end to the conversion back end.
// ----------------------------------------------------------------------------
package urd_pkg;

  localparam int NUM_DIGITS  = 4;
  localparam int POS_W       = 2;
  localparam int COUNT_W     = 16;
  localparam int DIST_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] SCAN_PERIOD_RST   = 16'd2000;
  localparam logic [9:0]  TRIGGER_EVERY_RST = 10'd400;
  localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd20;

  // Reciprocal of 1000 scaled by 2^31, exact for products below 2^21.
  localparam logic [21:0] RECIP_1000 = 22'd2147484;
  localparam int          RECIP_SHIFT = 31;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [7:0] SEG_DP_MASK = 8'h7f;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_PERIOD   = 2'd0,
    REG_TRIGGER_EVERY = 2'd1,
    REG_TRIGGER_WIDTH = 2'd2
  } urd_reg_t;

  typedef struct packed {
    logic             trig;
    logic [POS_W-1:0] pos;
    logic             done;
  } urd_ctrl_t;

  typedef struct packed {
    urd_ctrl_t          ctrl;
    logic               over;
    logic [COUNT_W-1:0] count;
  } urd_item_t;

  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'hc0;
      4'd1:    pat = 8'hf9;
      4'd2:    pat = 8'ha4;
      4'd3:    pat = 8'hb0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hf8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h98;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

  function automatic logic [NUM_DIGITS-1:0] sel_font(input logic [POS_W-1:0] pos);
    logic [NUM_DIGITS-1:0] sel;
    unique case (pos)
      2'd0:    sel = 4'he;
      2'd1:    sel = 4'hd;
      2'd2:    sel = 4'hb;
      default: sel = 4'h7;
    endcase
    return sel;
  endfunction

endpackage

FILE: rtl/urd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_ifs: channel interfaces
// Valid/ready channels for the tick input, the result output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface urd_in_if;
  logic valid;
  logic ready;
  logic echo;
  modport source (output valid, output echo, input ready);
  modport sink (input valid, input echo, output ready);
endinterface

interface urd_out_if;
  import urd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  trigger;
  logic [NUM_DIGITS-1:0] digit_select;
  logic [7:0]            segments;
  logic [DIST_W-1:0]     distance;
  logic                  reading_done;
  logic                  over_range;
  modport source (output valid, output trigger, output digit_select, output segments,
                  output distance, output reading_done, output over_range, input ready);
  modport sink (input valid, input trigger, input digit_select, input segments,
                input distance, input reading_done, input over_range, output ready);
endinterface

interface urd_cfg_if;
  import urd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/urd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_front: tick front end
// Holds the configuration registers, counts echo ticks, runs the display
// scan and trigger counters and emits one word per accepted tick.
// ----------------------------------------------------------------------------
module urd_front (
  input  logic               clk,
  input  logic               rst_n,
  urd_in_if.sink             in_ch,
  urd_cfg_if.sink            cfg_ch,
  output urd_pkg::urd_item_t item,
  output logic               item_valid,
  input  logic               item_ready
);
  import urd_pkg::*;

  logic [15:0]        scan_period_r;
  logic [9:0]         trigger_every_r;
  logic [7:0]         trigger_width_r;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               last_r;
  logic [15:0]        div_r, div_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [9:0]         spacing_r, spacing_nxt;
  logic [7:0]         left_r, left_nxt;

  logic [16:0]        div_sum;
  logic [10:0]        spacing_sum;
  logic               trig;
  logic               done;
  logic               accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = item_ready;
  assign item_valid   = in_ch.valid;
  assign accept       = in_ch.valid & item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r   <= SCAN_PERIOD_RST;
      trigger_every_r <= TRIGGER_EVERY_RST;
      trigger_width_r <= TRIGGER_WIDTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SCAN_PERIOD:   scan_period_r   <= cfg_ch.data;
        REG_TRIGGER_EVERY: trigger_every_r <= cfg_ch.data[9:0];
        REG_TRIGGER_WIDTH: trigger_width_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trig        = (left_r != 8'd0);
    left_nxt    = trig ? left_r - 8'd1 : left_r;
    count_nxt   = count_r;
    done        = 1'b0;
    if (in_ch.echo) begin
      if (count_r != '1) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end else if (last_r) begin
      done      = 1'b1;
      count_nxt = '0;
    end

    div_sum     = {1'b0, div_r} + 17'd1;
    spacing_sum = {1'b0, spacing_r} + 11'd1;
    pos_nxt     = pos_r;
    spacing_nxt = spacing_r;
    if (div_sum >= {1'b0, scan_period_r}) begin
      div_nxt = '0;
      pos_nxt = pos_r + POS_W'(1);
      if (spacing_sum >= {1'b0, trigger_every_r}) begin
        spacing_nxt = '0;
        left_nxt    = trigger_width_r;
      end else begin
        spacing_nxt = spacing_sum[9:0];
      end
    end else begin
      div_nxt = div_sum[15:0];
    end

    item.ctrl.trig = trig;
    item.ctrl.pos  = pos_nxt;
    item.ctrl.done = done;
    item.over      = (count_r == '1);
    item.count     = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      last_r    <= 1'b0;
      div_r     <= '0;
      pos_r     <= '0;
      spacing_r <= '0;
      left_r    <= '0;
    end else if (accept) begin
      count_r   <= count_nxt;
      last_r    <= in_ch.echo;
      div_r     <= div_nxt;
      pos_r     <= pos_nxt;
      spacing_r <= spacing_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

FILE: rtl/urd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_queue: decoupling queue
// Short first-in first-out buffer of words between front and back end.
// ----------------------------------------------------------------------------
module urd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  urd_pkg::urd_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output urd_pkg::urd_item_t pop_item
);
  import urd_pkg::*;

  urd_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              push;
  logic              pop;

  assign push_ready = (fill_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/urd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_back: conversion and display back end
// Five-stage pipeline turning an echo count into distance and three digits,
// then an output register that holds the latest reading and drives the word.
// ----------------------------------------------------------------------------
module urd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  urd_pkg::urd_item_t item,
  urd_out_if.source          out_ch
);
  import urd_pkg::*;

  logic              advance;

  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  urd_ctrl_t         c1_r, c2_r, c3_r, c4_r, c5_r;
  logic              o1_r, o2_r, o3_r, o4_r, o5_r;
  logic [20:0]       p1_r;
  logic [DIST_W-1:0] d2_r, d3_r, d4_r, d5_r;
  logic [9:0]        r3_r;
  logic [3:0]        h3_r, h4_r, h5_r;
  logic [6:0]        rem4_r;
  logic [3:0]        t5_r, u5_r;

  logic [42:0]       prod2;
  logic [9:0]        r3_nxt;
  logic [15:0]       hprod3;
  logic [9:0]        diff4;
  logic [14:0]       tprod5;
  logic [3:0]        t5_nxt;
  logic [6:0]        u5_wide;

  logic              out_valid_r;
  logic              trig_r;
  logic [NUM_DIGITS-1:0] sel_r;
  logic [7:0]        seg_r;
  logic              done_r;
  logic [DIST_W-1:0] dist_held_r, dist_held_nxt;
  logic              over_held_r, over_held_nxt;
  logic [3:0]        units_r, units_nxt;
  logic [3:0]        tens_r, tens_nxt;
  logic [3:0]        hund_r, hund_nxt;
  logic [7:0]        seg_nxt;

  assign advance    = !out_valid_r || out_ch.ready;
  assign item_ready = advance;

  always_comb begin
    prod2   = {22'd0, p1_r} * {21'd0, RECIP_1000};
    r3_nxt  = (d2_r >= 11'd1000) ? 10'(d2_r - 11'd1000) : d2_r[9:0];
    hprod3  = {6'd0, r3_nxt} * 16'd41;
    diff4   = r3_r - 10'(h3_r * 7'd100);
    tprod5  = {8'd0, rem4_r} * 15'd205;
    t5_nxt  = tprod5[14:11];
    u5_wide = rem4_r - 7'(t5_nxt * 4'd10);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_r   <= item.ctrl;
      o1_r   <= item.over;
      p1_r   <= {5'd0, item.count} * 21'd17;
      c2_r   <= c1_r;
      o2_r   <= o1_r;
      d2_r   <= prod2[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
      c3_r   <= c2_r;
      o3_r   <= o2_r;
      d3_r   <= d2_r;
      r3_r   <= r3_nxt;
      h3_r   <= hprod3[15:12];
      c4_r   <= c3_r;
      o4_r   <= o3_r;
      d4_r   <= d3_r;
      h4_r   <= h3_r;
      rem4_r <= diff4[6:0];
      c5_r   <= c4_r;
      o5_r   <= o4_r;
      d5_r   <= d4_r;
      h5_r   <= h4_r;
      t5_r   <= t5_nxt;
      u5_r   <= u5_wide[3:0];
    end
  end

  always_comb begin
    dist_held_nxt = dist_held_r;
    over_held_nxt = over_held_r;
    units_nxt     = units_r;
    tens_nxt      = tens_r;
    hund_nxt      = hund_r;
    if (c5_r.done) begin
      dist_held_nxt = d5_r;
      over_held_nxt = o5_r;
      units_nxt     = u5_r;
      tens_nxt      = t5_r;
      hund_nxt      = h5_r;
    end
    unique case (c5_r.pos)
      2'd0:    seg_nxt = seg_font(units_nxt);
      2'd1:    seg_nxt = seg_font(tens_nxt);
      2'd2:    seg_nxt = seg_font(hund_nxt) & SEG_DP_MASK;
      default: seg_nxt = SEG_BLANK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      dist_held_r <= '0;
      over_held_r <= 1'b0;
      units_r     <= '0;
      tens_r      <= '0;
      hund_r      <= '0;
    end else if (advance) begin
      v1_r        <= item_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
      if (v5_r) begin
        dist_held_r <= dist_held_nxt;
        over_held_r <= over_held_nxt;
        units_r     <= units_nxt;
        tens_r      <= tens_nxt;
        hund_r      <= hund_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v5_r) begin
      trig_r <= c5_r.trig;
      sel_r  <= sel_font(c5_r.pos);
      seg_r  <= seg_nxt;
      done_r <= c5_r.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.trigger      = trig_r;
  assign out_ch.digit_select = sel_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.distance     = dist_held_r;
  assign out_ch.reading_done = done_r;
  assign out_ch.over_range   = over_held_r;

endmodule

FILE: rtl/ultrasonic_range_display_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_display_unit: ultrasonic ranging controller with display
// Counts echo ticks, converts each echo pulse to distance and digits, and
// drives a multiplexed seven-segment display and the ranging trigger.
// ----------------------------------------------------------------------------
// Usage:
// Each word on in_ch is one microsecond tick carrying the sampled echo level.
// Every accepted tick yields exactly one word on out_ch, in order, with the
// trigger level, digit enables, segment pattern and the latest reading.
// cfg_ch writes scan_period, trigger_every and trigger_width by index; it is
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. Each tick's result word passes through the
// decoupling queue and five conversion stages, then the output register.
// Throughput is one tick per cycle while the receiver does not stall; the
// front-end counters update once per accepted tick.
// Reset loads the register defaults and clears all counters, the held
// reading and the digits; no output word is pending after reset.
// When the receiver stalls, the output word holds, the conversion pipeline
// freezes and the two-entry queue absorbs ticks until in_ch.ready drops.
// ----------------------------------------------------------------------------
module ultrasonic_range_display_unit (
  input logic       clk,
  input logic       rst_n,
  urd_in_if.sink    in_ch,
  urd_out_if.source out_ch,
  urd_cfg_if.sink   cfg_ch
);
  import urd_pkg::*;

  urd_item_t front_item;
  logic      front_valid;
  logic      front_ready;
  urd_item_t back_item;
  logic      back_valid;
  logic      back_ready;

  urd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  urd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  urd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .out_ch     (out_ch)
  );

endmodule

FILE: rtl/urd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_checker: output port checks
// Concurrent assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module urd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        trigger,
  input logic [3:0]  digit_select,
  input logic [7:0]  segments,
  input logic [10:0] distance,
  input logic        reading_done,
  input logic        over_range
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(trigger) && $stable(digit_select)
      && $stable(segments) && $stable(distance) && $stable(reading_done)
      && $stable(over_range))
    else $error("Stalled output word changed.");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(~digit_select) == 1)
    else $error("Digit enable is not one-cold.");

  a_blank_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && digit_select == 4'h7 |-> segments == 8'hff)
    else $error("Blank digit position lights segments.");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (reading_done || over_range) |-> distance <= 11'd1114
      && (!over_range || distance == 11'd1114))
    else $error("Distance outside the reachable range.");

endmodule

bind ultrasonic_range_display_unit urd_checker u_urd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .trigger      (out_ch.trigger),
  .digit_select (out_ch.digit_select),
  .segments     (out_ch.segments),
  .distance     (out_ch.distance),
  .reading_done (out_ch.reading_done),
  .over_range   (out_ch.over_range)
);

FILE: test/ultrasonic_range_display_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_display_unit_tb: self-checking testbench for the ranging unit
// Sends echo ticks through the valid/ready input channel while a tick-by-tick
// model of the counters, the distance conversion, the display multiplex and
// the trigger predicts every output word. A directed table covers reset,
// a short reading, zero and extreme register values and lowered limits.
// Three random phases with changing idle rates on both channels follow.
// ----------------------------------------------------------------------------
module ultrasonic_range_display_unit_tb;
  import urd_pkg::*;

  typedef struct packed {
    logic                  trigger;
    logic [NUM_DIGITS-1:0] digit_select;
    logic [7:0]            segments;
    logic [DIST_W-1:0]     distance;
    logic                  reading_done;
    logic                  over_range;
  } display_word_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  level;
    int                    reps;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_value;
    bit                    typed;
    display_word_t         want;
  } stim_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_ROWS     = 37;
  localparam int EPISODES     = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 50;

  localparam logic [7:0] DIGIT_GLYPH [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h98, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
  };

  localparam display_word_t NO_WORD = '0;
  localparam display_word_t IDLE_WORD = '{trigger: 1'b0, digit_select: 4'he,
      segments: 8'hc0, distance: 11'd0, reading_done: 1'b0, over_range: 1'b0};
  localparam display_word_t READING_WORD = '{trigger: 1'b0, digit_select: 4'he,
      segments: 8'hf9, distance: 11'd1, reading_done: 1'b1, over_range: 1'b0};
  localparam display_word_t READING_HELD = '{trigger: 1'b0, digit_select: 4'he,
      segments: 8'hf9, distance: 11'd1, reading_done: 1'b0, over_range: 1'b0};

  logic clk = 1'b0;
  logic rst_n;

  urd_in_if  in_ch ();
  urd_out_if out_ch ();
  urd_cfg_if cfg_ch ();

  ultrasonic_range_display_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the block's registers and state.
  logic [15:0]       scan_period_reg   = SCAN_PERIOD_RST;
  logic [9:0]        trigger_every_reg = TRIGGER_EVERY_RST;
  logic [7:0]        trigger_width_reg = TRIGGER_WIDTH_RST;
  logic [15:0]       echo_ticks    = '0;
  logic              echo_prev     = 1'b0;
  logic [15:0]       scan_ticks    = '0;
  logic [POS_W-1:0]  scan_slot     = '0;
  logic [9:0]        step_count    = '0;
  logic [7:0]        pulse_left    = '0;
  logic [3:0]        shown_digits [3] = '{4'd0, 4'd0, 4'd0};
  logic [DIST_W-1:0] held_distance = '0;
  logic              held_over     = 1'b0;

  display_word_t expected_words [$];
  int  failures      = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  tick_offered  = 1'b0;
  bit  write_offered = 1'b0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_TICK,  1'b0, 1,     REG_SCAN_PERIOD,   16'd0,     1'b1, IDLE_WORD},
    '{ROW_TICK,  1'b0, 1,     REG_SCAN_PERIOD,   16'd0,     1'b1, IDLE_WORD},
    '{ROW_TICK,  1'b1, 59,    REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 1,     REG_SCAN_PERIOD,   16'd0,     1'b1, READING_WORD},
    '{ROW_TICK,  1'b0, 1,     REG_SCAN_PERIOD,   16'd0,     1'b1, READING_HELD},
    '{ROW_TICK,  1'b1, 59,    REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 1,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd1,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'd1,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_WIDTH, 16'd2,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b1, 3,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 4,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_WIDTH, 16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b1, 60,    REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 4,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_WIDTH, 16'd255,   1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 6,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'hfc03,  1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_UNUSED,        16'hffff,  1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 8,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd65535, 1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'd1023,  1'b0, NO_WORD},
    '{ROW_TICK,  1'b1, 2,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 2,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd6,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 4,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd2,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 3,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_SCAN_PERIOD,   16'd1,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'd5,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 3,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_WRITE, 1'b0, 0,     REG_TRIGGER_EVERY, 16'd1,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 3,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b1, 40,    REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD},
    '{ROW_TICK,  1'b0, 4,     REG_SCAN_PERIOD,   16'd0,     1'b0, NO_WORD}
  };

  function automatic display_word_t predict_tick(input logic level);
    display_word_t w;
    int unsigned   span;
    w = '0;
    if (pulse_left != 8'd0) begin
      w.trigger  = 1'b1;
      pulse_left = pulse_left - 8'd1;
    end
    if (level) begin
      if (echo_ticks != 16'hffff) echo_ticks = echo_ticks + 16'd1;
    end else if (echo_prev) begin
      span            = (32'(echo_ticks) * 32'd17) / 32'd1000;
      held_distance   = span[DIST_W-1:0];
      held_over       = (echo_ticks == 16'hffff);
      span            = span % 32'd1000;
      shown_digits[2] = 4'(span / 32'd100);
      shown_digits[1] = 4'((span % 32'd100) / 32'd10);
      shown_digits[0] = 4'(span % 32'd10);
      echo_ticks      = '0;
      w.reading_done  = 1'b1;
    end
    echo_prev = level;
    if (32'(scan_ticks) + 32'd1 >= 32'(scan_period_reg)) begin
      scan_ticks = '0;
      scan_slot  = scan_slot + 2'd1;
      if (32'(step_count) + 32'd1 >= 32'(trigger_every_reg)) begin
        step_count = '0;
        pulse_left = trigger_width_reg;
      end else begin
        step_count = step_count + 10'd1;
      end
    end else begin
      scan_ticks = scan_ticks + 16'd1;
    end
    w.digit_select = ~(4'b0001 << scan_slot);
    case (scan_slot)
      2'd0:    w.segments = DIGIT_GLYPH[shown_digits[0]];
      2'd1:    w.segments = DIGIT_GLYPH[shown_digits[1]];
      2'd2:    w.segments = DIGIT_GLYPH[shown_digits[2]] & SEG_DP_MASK;
      default: w.segments = SEG_BLANK;
    endcase
    w.distance   = held_distance;
    w.over_range = held_over;
    return w;
  endfunction

  task automatic stop_ticks();
    if (tick_offered) begin
      in_ch.valid <= 1'b0;
      tick_offered = 1'b0;
    end
  endtask

  task automatic stop_writes();
    if (write_offered) begin
      cfg_ch.valid <= 1'b0;
      write_offered = 1'b0;
    end
  endtask

  task automatic send_tick(input logic level, input bit typed, input display_word_t want);
    display_word_t predicted;
    stop_writes();
    while ($urandom_range(99) < send_idle_pct) begin
      stop_ticks();
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    tick_offered = 1'b1;
    in_ch.echo <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_tick(level);
    expected_words.push_back(typed ? want : predicted);
  endtask

  // Registers change only once every expected word has been taken.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    stop_ticks();
    while (expected_words.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    write_offered = 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SCAN_PERIOD:   scan_period_reg   = value;
      REG_TRIGGER_EVERY: trigger_every_reg = value[9:0];
      REG_TRIGGER_WIDTH: trigger_width_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_random_setting();
    write_register(REG_SCAN_PERIOD, 16'($urandom_range(0, 6)));
    write_register(REG_TRIGGER_EVERY, 16'($urandom_range(0, 6)));
    write_register(REG_TRIGGER_WIDTH, 16'($urandom_range(0, 12)));
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                  input bit with_long);
    int pick;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    write_random_setting();
    for (int ep = 0; ep < EPISODES; ep++) begin
      if (ep == EPISODES / 2) begin
        if (with_long) begin
          write_register(REG_SCAN_PERIOD, 16'd1);
          write_register(REG_TRIGGER_EVERY, 16'd1023);
          write_register(REG_TRIGGER_WIDTH, 16'd255);
        end else begin
          write_random_setting();
        end
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), 1'b0, NO_WORD);
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'b0, NO_WORD);
        if (pick < 88)
          repeat ($urandom_range(1, 12)) send_tick(1'b1, 1'b0, NO_WORD);
        else
          repeat ($urandom_range(13, 60)) send_tick(1'b1, 1'b0, NO_WORD);
        send_tick(1'b0, 1'b0, NO_WORD);
      end
    end
    if (with_long) begin
      repeat (3) begin
        repeat ($urandom_range(20, 60)) send_tick(1'b1, 1'b0, NO_WORD);
        repeat ($urandom_range(1, 5)) send_tick(1'b0, 1'b0, NO_WORD);
      end
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    display_word_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: word with none expected, expected nothing actual 0x%0h", $time,
                   {out_ch.trigger, out_ch.digit_select, out_ch.segments,
                    out_ch.distance, out_ch.reading_done, out_ch.over_range});
      end else begin
        want = expected_words.pop_front();
        compare_field("trigger", want.trigger, out_ch.trigger);
        compare_field("digit_select", want.digit_select, out_ch.digit_select);
        compare_field("segments", want.segments, out_ch.segments);
        compare_field("distance", want.distance, out_ch.distance);
        compare_field("reading_done", want.reading_done, out_ch.reading_done);
        compare_field("over_range", want.over_range, out_ch.over_range);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.echo   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SCAN_PERIOD;
    cfg_ch.data  = '0;
    send_idle_pct = 35;
    recv_idle_pct = 55;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE)
        write_register(directed_rows[r].reg_idx, directed_rows[r].reg_value);
      else
        repeat (directed_rows[r].reps)
          send_tick(directed_rows[r].level, directed_rows[r].typed, directed_rows[r].want);
    end

    run_random_phase(35, 55, 1'b0);
    run_random_phase(55, 35, 1'b0);
    run_random_phase(0, 0, 1'b1);

    stop_ticks();
    stop_writes();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("ultrasonic_range_display_unit regression: pass");
    else
      $display("ultrasonic_range_display_unit regression: fail");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("ultrasonic_range_display_unit regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/urd_pkg.sv
rtl/urd_ifs.sv
rtl/urd_front.sv
rtl/urd_queue.sv
rtl/urd_back.sv
rtl/ultrasonic_range_display_unit.sv
rtl/urd_checker.sv
test/ultrasonic_range_display_unit_tb.sv
